// ===== rtl/stbs_pkg.sv =====
// Shared constants and types for the sorted table binary search block.
`timescale 1ns / 1ps

package stbs_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = ADDR_W + 1;
  localparam int DATA_W      = 32;

  // Operation codes carried by an input item.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // One access to the table memory.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } ram_req_t;

endpackage

// ===== rtl/stbs_channels.sv =====
// Handshake channel interfaces for the sorted table binary search block.
`timescale 1ns / 1ps

// Request channel: table writes and searches.
interface stbs_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [stbs_pkg::ADDR_W-1:0] slot;
  logic signed [stbs_pkg::DATA_W-1:0] entry_value;
  logic signed [stbs_pkg::DATA_W-1:0] search_key;

  modport source (output valid, input ready, output operation, output slot,
                  output entry_value, output search_key);
  modport sink   (input valid, output ready, input operation, input slot,
                  input entry_value, input search_key);
endinterface

// Result channel: one item per search.
interface stbs_res_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [stbs_pkg::ADDR_W-1:0] position;

  modport source (output valid, input ready, output found, output position);
  modport sink   (input valid, output ready, input found, input position);
endinterface

// Configuration channel: the entry count register.
interface stbs_cfg_if;
  logic        valid;
  logic        ready;
  logic [stbs_pkg::COUNT_W-1:0] entry_count;

  modport source (output valid, input ready, output entry_count);
  modport sink   (input valid, output ready, input entry_count);
endinterface

// ===== rtl/stbs_ram.sv =====
// Generic single-port synchronous RAM with a registered read port.
`timescale 1ns / 1ps

module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable; the read data is registered every cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/stbs_search.sv =====
// Search controller: drives the table memory and runs one probe per cycle.
`timescale 1ns / 1ps

module stbs_search (
  input  logic                          clk,
  input  logic                          rst,
  stbs_req_if.sink                      request,
  stbs_res_if.source                    result,
  input  logic [stbs_pkg::COUNT_W-1:0]  count,
  output stbs_pkg::ram_req_t            ram_req,
  input  logic [stbs_pkg::DATA_W-1:0]   ram_rdata
);

  typedef enum logic [1:0] {
    IDLE,
    SEARCH,
    RESULT
  } state_t;

  state_t                        state;
  logic [stbs_pkg::COUNT_W-1:0]  low;
  logic [stbs_pkg::COUNT_W-1:0]  hi_ex;
  logic [stbs_pkg::ADDR_W-1:0]   mid;
  logic signed [stbs_pkg::DATA_W-1:0] key;
  logic                          hit;
  logic [stbs_pkg::ADDR_W-1:0]   where_slot;

  logic                          accept;
  logic                          is_search;
  logic [stbs_pkg::COUNT_W-1:0]  count_m1;
  logic [stbs_pkg::ADDR_W-1:0]   mid_start;
  logic signed [stbs_pkg::DATA_W-1:0] probe;
  logic                          key_lt;
  logic                          key_eq;
  logic [stbs_pkg::COUNT_W-1:0]  mid_ext;
  logic [stbs_pkg::COUNT_W-1:0]  low_next;
  logic [stbs_pkg::COUNT_W-1:0]  hi_ex_next;
  logic [stbs_pkg::COUNT_W:0]    span_sum;
  logic [stbs_pkg::ADDR_W-1:0]   mid_next;
  logic                          range_empty;
  logic                          out_free;

  assign request.ready = (state == IDLE);
  assign accept        = request.valid && request.ready;
  assign is_search     = (request.operation == stbs_pkg::OP_SEARCH);
  assign out_free      = !result.valid || result.ready;

  // First midpoint is floor((count-1)/2).
  assign count_m1  = count - stbs_pkg::COUNT_W'(1);
  assign mid_start = count_m1[stbs_pkg::ADDR_W:1];

  // Compare the probed entry and narrow the range [low, hi_ex).
  assign probe   = $signed(ram_rdata);
  assign key_lt  = key < probe;
  assign key_eq  = key == probe;
  assign mid_ext = {1'b0, mid};

  always_comb begin
    low_next   = low;
    hi_ex_next = hi_ex;
    if (key_lt) begin
      hi_ex_next = mid_ext;
    end else begin
      low_next = mid_ext + stbs_pkg::COUNT_W'(1);
    end
  end

  assign range_empty = (low_next >= hi_ex_next);
  assign span_sum    = {1'b0, low_next} + {1'b0, hi_ex_next} - (stbs_pkg::COUNT_W + 1)'(1);
  assign mid_next    = span_sum[stbs_pkg::ADDR_W:1];

  // Memory port: writes from the request channel, reads from the prober.
  always_comb begin
    ram_req.we    = accept && !is_search;
    ram_req.wdata = request.entry_value;
    ram_req.addr  = request.slot;
    if (state == SEARCH) begin
      ram_req.addr = mid_next;
    end else if (is_search) begin
      ram_req.addr = mid_start;
    end
  end

  // Sequencer and output register; the result state reloads a register it frees.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready && (state != RESULT)) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept && is_search) begin
            key   <= request.search_key;
            low   <= '0;
            hi_ex <= count;
            mid   <= mid_start;
            hit   <= 1'b0;
            where_slot <= '0;
            state <= (count == '0) ? RESULT : SEARCH;
          end
        end
        SEARCH: begin
          if (key_eq) begin
            hit        <= 1'b1;
            where_slot <= mid;
            state      <= RESULT;
          end else begin
            low   <= low_next;
            hi_ex <= hi_ex_next;
            mid   <= mid_next;
            if (range_empty) begin
              state <= RESULT;
            end
          end
        end
        RESULT: begin
          if (out_free) begin
            result.valid    <= 1'b1;
            result.found    <= hit;
            result.position <= where_slot;
            state           <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // The probe always lies inside the live range.
  a_mid_in_range: assert property (@(posedge clk) disable iff (rst)
    state == SEARCH |-> (mid_ext >= low) && (mid_ext < hi_ex))
    else $error("probe slot outside the search range");

  // The range never reaches past the table.
  a_hi_bound: assert property (@(posedge clk) disable iff (rst)
    state == SEARCH |-> hi_ex <= stbs_pkg::COUNT_W'(stbs_pkg::TABLE_DEPTH))
    else $error("search range exceeds the table depth");

  // A miss always reports slot zero.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.found |-> result.position == '0)
    else $error("miss reported with a nonzero position");

  // A loaded result comes only from the result state.
  a_load_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state) == RESULT)
    else $error("result loaded outside the result state");

endmodule

// ===== rtl/sorted_table_binary_search.sv =====
// Top level of the sorted table binary search block.
// The block holds a table of 1024 signed 32-bit entries kept in ascending order
// by software. The request channel carries write items (operation 0: store
// entry_value at slot) and search items (operation 1: look up search_key in
// slots 0 to entry_count-1). A write gives no result; a search gives one result
// item with found and position (position is 0 on a miss).
// The cfg channel writes entry_count; it is always ready. The user must write it
// only while the block is idle; the block itself does not enforce this. Counts
// above the table depth act as the full table. A write is stored in the cycle
// it is accepted. A search starts on acceptance, runs one probe per cycle (one
// synchronous read of the table memory each), then loads the output register;
// an early match ends the probes sooner. Items are taken one at a time; ready
// is high only while no search is in progress.
// The result waits in an output register. If the receiver stalls, the next
// item can still be accepted and run; a second result then holds in the
// sequencer, with request ready low, until the register frees up.
// Reset clears entry_count to zero and empties the output register; table
// contents are undefined until written.
`timescale 1ns / 1ps

module sorted_table_binary_search (
  input  logic       clk,
  input  logic       rst,
  stbs_req_if.sink   request,
  stbs_res_if.source result,
  stbs_cfg_if.sink   cfg
);

  logic [stbs_pkg::COUNT_W-1:0] count;
  stbs_pkg::ram_req_t           ram_req;
  logic [stbs_pkg::DATA_W-1:0]  ram_rdata;

  // Entry count register, saturated to the table depth on write.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.entry_count > stbs_pkg::COUNT_W'(stbs_pkg::TABLE_DEPTH)) begin
        count <= stbs_pkg::COUNT_W'(stbs_pkg::TABLE_DEPTH);
      end else begin
        count <= cfg.entry_count;
      end
    end
  end

  // Table memory.
  stbs_ram #(
    .WIDTH (stbs_pkg::DATA_W),
    .DEPTH (stbs_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_req.we),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .rdata (ram_rdata)
  );

  // Search sequencer.
  stbs_search u_search (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .result    (result),
    .count     (count),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the sorted table binary search block.
`timescale 1ns / 1ps

module tb_top;

  localparam int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH;
  localparam int ADDR_W      = stbs_pkg::ADDR_W;
  localparam int COUNT_W     = stbs_pkg::COUNT_W;
  localparam int DATA_W      = stbs_pkg::DATA_W;

  localparam int TOTAL_ITEMS   = 1900;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int REPORT_LIMIT  = 10;
  localparam int DIRECTED_ROWS = 25;

  localparam logic [DATA_W-1:0] VALUE_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] VALUE_NEG = 32'hFFFF_FFFF;

  // One search answer as the result channel carries it.
  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] position;
  } lookup_t;

  localparam lookup_t MISS = '{1'b0, 10'd0};

  // One row of the directed stimulus: a table write, a search, or a count setting.
  typedef enum logic [1:0] {ROW_WRITE, ROW_SEARCH, ROW_COUNT} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [ADDR_W-1:0] slot;
    logic [DATA_W-1:0] data;
    logic              fixed;
    lookup_t           answer;
  } stim_row_t;

  // Directed part: empty table, extremes, duplicates, an unsorted table.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_SEARCH, 10'd0,    32'h0000_0000, 1'b1, MISS},
    '{ROW_WRITE,  10'd0,    VALUE_MIN,     1'b0, MISS},
    '{ROW_WRITE,  10'd1,    VALUE_NEG,     1'b0, MISS},
    '{ROW_WRITE,  10'd2,    32'h0000_0000, 1'b0, MISS},
    '{ROW_WRITE,  10'd3,    VALUE_MAX,     1'b0, MISS},
    '{ROW_WRITE,  10'd1023, 32'h5A5A_5A5A, 1'b0, MISS},
    '{ROW_COUNT,  10'd0,    32'd4,         1'b0, MISS},
    '{ROW_SEARCH, 10'd0,    VALUE_MIN,     1'b1, '{1'b1, 10'd0}},
    '{ROW_SEARCH, 10'd0,    VALUE_MAX,     1'b1, '{1'b1, 10'd3}},
    '{ROW_SEARCH, 10'd0,    VALUE_NEG,     1'b0, MISS},
    '{ROW_SEARCH, 10'd0,    32'h0000_0000, 1'b0, MISS},
    '{ROW_SEARCH, 10'd0,    32'h0000_0001, 1'b0, MISS},
    '{ROW_COUNT,  10'd0,    32'd1,         1'b0, MISS},
    '{ROW_SEARCH, 10'd0,    VALUE_MIN,     1'b1, '{1'b1, 10'd0}},
    '{ROW_SEARCH, 10'd0,    VALUE_MAX,     1'b1, MISS},
    '{ROW_WRITE,  10'd3,    32'h0000_0000, 1'b0, MISS},
    '{ROW_WRITE,  10'd4,    VALUE_MAX,     1'b0, MISS},
    '{ROW_COUNT,  10'd0,    32'd5,         1'b0, MISS},
    '{ROW_SEARCH, 10'd0,    32'h0000_0000, 1'b0, MISS},
    '{ROW_SEARCH, 10'd0,    VALUE_MAX,     1'b0, MISS},
    '{ROW_WRITE,  10'd0,    VALUE_MAX,     1'b0, MISS},
    '{ROW_SEARCH, 10'd0,    VALUE_MAX,     1'b0, MISS},
    '{ROW_SEARCH, 10'd0,    VALUE_MIN,     1'b0, MISS},
    '{ROW_COUNT,  10'd0,    32'd0,         1'b0, MISS},
    '{ROW_SEARCH, 10'd0,    VALUE_MAX,     1'b1, MISS}
  };

  logic clk = 1'b0;
  logic rst;

  stbs_req_if req_ch ();
  stbs_res_if res_ch ();
  stbs_cfg_if cfg_ch ();

  sorted_table_binary_search dut (
    .clk     (clk),
    .rst     (rst),
    .request (req_ch),
    .result  (res_ch),
    .cfg     (cfg_ch)
  );

  // Shadow copy of the table and the count register.
  logic signed [DATA_W-1:0] table_image [TABLE_DEPTH];
  logic [COUNT_W-1:0]       count_setting;
  lookup_t                  pending_lookups [$];

  int items_done = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int sender_idle_pct = 27;
  int receiver_stall_pct = 84;

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Binary search over the in-use slots, with the midpoint rounded down.
  function automatic lookup_t predict_search(logic signed [DATA_W-1:0] key);
    int      lo;
    int      hi;
    int      mid;
    lookup_t answer;
    lo = 0;
    hi = ((count_setting > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_setting)) - 1;
    answer = MISS;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (key < table_image[mid]) begin
        hi = mid - 1;
      end else if (key > table_image[mid]) begin
        lo = mid + 1;
      end else begin
        answer.hit = 1'b1;
        answer.position = mid[ADDR_W-1:0];
        lo = hi + 1;
      end
    end
    return answer;
  endfunction

  // Offer one item after a random gap and record what it should cause.
  task automatic send_request(logic op, logic [ADDR_W-1:0] slot, logic [DATA_W-1:0] value,
                              logic [DATA_W-1:0] key, logic fixed, lookup_t answer);
    // Idle mix moves through three stages as the run progresses.
    if (items_done < TOTAL_ITEMS / 3) begin
      sender_idle_pct = 27;
      receiver_stall_pct = 84;
    end else if (items_done < 2 * TOTAL_ITEMS / 3) begin
      sender_idle_pct = 84;
      receiver_stall_pct = 27;
    end else begin
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
    end
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk);
    req_ch.valid       <= 1'b1;
    req_ch.operation   <= op;
    req_ch.slot        <= slot;
    req_ch.entry_value <= value;
    req_ch.search_key  <= key;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    items_done++;
    if (op == stbs_pkg::OP_WRITE) begin
      table_image[slot] = value;
    end else begin
      pending_lookups.push_back(fixed ? answer : predict_search(key));
    end
  endtask

  // Stop sending and wait until every search has answered and the block is quiet.
  task automatic wait_for_idle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the entry count register while the block is idle.
  task automatic set_entry_count(logic [COUNT_W-1:0] entries);
    wait_for_idle();
    @(negedge clk);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.entry_count <= entries;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    count_setting = entries;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Fill slots 0 to entries-1 with ascending values, dense with duplicates or spread wide.
  task automatic fill_sorted(int entries);
    longint step_max;
    longint cur;
    case ($urandom_range(0, 2))
      0:       step_max = 2;
      1:       step_max = 1000;
      default: step_max = 64'hFFFF_FFFF / (entries + 1);
    endcase
    cur = -64'sd2147483648 +
          (longint'({32'b0, $urandom}) % (64'sh1_0000_0000 - entries * step_max));
    for (int i = 0; i < entries; i++) begin
      send_request(stbs_pkg::OP_WRITE, i[ADDR_W-1:0], cur[DATA_W-1:0], $urandom, 1'b0, MISS);
      cur += $urandom_range(0, step_max);
    end
  endtask

  // Searches for present keys, near misses and random keys, with a little write noise.
  task automatic run_searches(int searches);
    int                span;
    int                pick;
    int                roll;
    logic [DATA_W-1:0] key;
    span = (count_setting > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_setting);
    for (int k = 0; k < searches; k++) begin
      roll = $urandom_range(0, 99);
      pick = (span > 0) ? $urandom_range(0, span - 1) : 0;
      if (roll == 99) begin
        wait_for_idle();
      end
      if (roll < 6) begin
        send_request(stbs_pkg::OP_WRITE, ADDR_W'($urandom), $urandom, $urandom, 1'b0, MISS);
      end else begin
        if (span > 0 && roll < 65) begin
          key = table_image[pick];
        end else if (span > 0 && roll < 80) begin
          key = table_image[pick] + 1;
        end else if (span > 0 && roll < 90) begin
          key = table_image[pick] - 1;
        end else if (roll < 94) begin
          key = roll[0] ? VALUE_MAX : VALUE_MIN;
        end else begin
          key = $urandom;
        end
        send_request(stbs_pkg::OP_SEARCH, ADDR_W'($urandom), $urandom, key, 1'b0, MISS);
      end
    end
  endtask

  // Result receiver stalls at random.
  always @(negedge clk) begin
    res_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // Compare every accepted result with the oldest outstanding search.
  always @(posedge clk) begin
    lookup_t want;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (pending_lookups.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("%0t: result with no search outstanding: found=%0b position=%0d",
                   $time, res_ch.found, res_ch.position);
        end
      end else begin
        want = pending_lookups.pop_front();
        if (res_ch.found !== want.hit || res_ch.position !== want.position) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: expected found=%0b position=%0d, got found=%0b position=%0d",
                     $time, want.hit, want.position, res_ch.found, res_ch.position);
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Main sequence: reset, directed rows, full table, then small random phases.
  initial begin
    int phase_roll;
    int entries;
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.operation   = stbs_pkg::OP_WRITE;
    req_ch.slot        = '0;
    req_ch.entry_value = '0;
    req_ch.search_key  = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.entry_count = '0;
    count_setting      = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      case (directed_rows[r].kind)
        ROW_COUNT: begin
          set_entry_count(directed_rows[r].data[COUNT_W-1:0]);
        end
        ROW_WRITE: begin
          send_request(stbs_pkg::OP_WRITE, directed_rows[r].slot, directed_rows[r].data,
                       $urandom, 1'b0, MISS);
        end
        default: begin
          send_request(stbs_pkg::OP_SEARCH, ADDR_W'($urandom), $urandom,
                       directed_rows[r].data, directed_rows[r].fixed,
                       directed_rows[r].answer);
        end
      endcase
    end

    // Populate the whole table once, then search it at full and oversized counts.
    fill_sorted(TABLE_DEPTH);
    set_entry_count(COUNT_W'(TABLE_DEPTH));
    run_searches(120);
    set_entry_count('1);
    run_searches(40);

    // Mostly small tables, now and then an empty or nearly full one.
    while (items_done < TOTAL_ITEMS) begin
      phase_roll = $urandom_range(0, 99);
      if (phase_roll < 10) begin
        set_entry_count('0);
        run_searches(8);
      end else if (phase_roll < 20) begin
        set_entry_count(COUNT_W'($urandom_range(900, TABLE_DEPTH)));
        run_searches(40);
      end else begin
        entries = (phase_roll < 50) ? $urandom_range(1, 4) :
                  (phase_roll < 80) ? $urandom_range(5, 40) : $urandom_range(41, 200);
        fill_sorted(entries);
        set_entry_count(COUNT_W'(entries));
        run_searches($urandom_range(20, 50));
      end
    end

    wait_for_idle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
